@@ rtl/fqsm_pkg.sv @@
// Shared command and status codes and the control structs of the cell chain.
`timescale 1ns / 1ps
`default_nettype none

package fqsm_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Per-word control that every cell sees at once.
   typedef struct packed {
      logic ins;
      logic shift;
      logic search;
   } cell_ctl_type;

   // Flag part of the scan token that walks from cell to cell.
   typedef struct packed {
      logic live;
      logic have;
      logic found;
   } tok_flags_type;

endpackage

`default_nettype wire

@@ rtl/fqsm_cell.sv @@
// One queue slot: holds a key, shifts toward the head, and updates the passing scan token.
`timescale 1ns / 1ps
`default_nettype none

module fqsm_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int INDEX_WIDTH = 4,
   parameter int CELL_INDEX  = 0
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire fqsm_pkg::cell_ctl_type       ctl,
   input  wire logic signed [KEY_WIDTH-1:0]  wr_key,
   input  wire logic signed [KEY_WIDTH-1:0]  find_key,
   input  wire                               prev_valid,
   input  wire                               next_valid,
   input  wire logic signed [KEY_WIDTH-1:0]  next_key,
   output logic                              valid,
   output logic signed [KEY_WIDTH-1:0]       key,
   input  wire fqsm_pkg::tok_flags_type      tok_in_flags,
   input  wire logic [INDEX_WIDTH-1:0]       tok_in_pos,
   input  wire logic signed [KEY_WIDTH-1:0]  tok_in_min,
   input  wire logic signed [KEY_WIDTH-1:0]  tok_in_max,
   output fqsm_pkg::tok_flags_type           tok_out_flags,
   output logic [INDEX_WIDTH-1:0]            tok_out_pos,
   output logic signed [KEY_WIDTH-1:0]       tok_out_min,
   output logic signed [KEY_WIDTH-1:0]       tok_out_max
);

   localparam logic [INDEX_WIDTH-1:0] MY_POS = INDEX_WIDTH'(CELL_INDEX);

   logic                           valid_ff, valid_in;
   logic signed [KEY_WIDTH-1:0]    key_ff, key_in;
   fqsm_pkg::tok_flags_type        flags_ff, flags_in;
   logic [INDEX_WIDTH-1:0]         pos_ff, pos_in;
   logic signed [KEY_WIDTH-1:0]    min_ff, min_in, max_ff, max_in;
   logic                           write_here;
   logic                           hit;

   // The first empty slot, at the head or behind an occupied one, takes the inserted word.
   assign write_here = ctl.ins & ~valid_ff & prev_valid;
   assign hit        = ctl.search & valid_ff & (key_ff == find_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctl.shift) begin
         valid_in = next_valid;
         key_in   = next_key;
      end else if (write_here) begin
         valid_in = 1'b1;
         key_in   = wr_key;
      end
   end

   always_comb begin
      flags_in.live  = tok_in_flags.live;
      flags_in.have  = tok_in_flags.have | valid_ff;
      flags_in.found = tok_in_flags.found | hit;
      pos_in         = (hit && !tok_in_flags.found) ? MY_POS : tok_in_pos;
      min_in         = tok_in_min;
      max_in         = tok_in_max;
      if (valid_ff) begin
         if (!tok_in_flags.have || key_ff < tok_in_min) begin
            min_in = key_ff;
         end
         if (!tok_in_flags.have || key_ff > tok_in_max) begin
            max_in = key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         flags_ff <= flags_in;
      end
      key_ff <= key_in;
      pos_ff <= pos_in;
      min_ff <= min_in;
      max_ff <= max_in;
   end

   assign valid         = valid_ff;
   assign key           = key_ff;
   assign tok_out_flags = flags_ff;
   assign tok_out_pos   = pos_ff;
   assign tok_out_min   = min_ff;
   assign tok_out_max   = max_ff;

endmodule

`default_nettype wire

@@ rtl/fifo_queue_search_min_max.sv @@
// Top level of the bounded queue with search and running minimum and maximum.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_command, req_value
// rsp_      out        rsp_valid/rsp_stall   rsp_status, rsp_removed_value, rsp_found,
//                                            rsp_match_position, rsp_item_count,
//                                            rsp_minimum, rsp_maximum
//
// After accept, a scan token starts from start_ff and walks the chain of QUEUE_DEPTH cells,
// one cell per cycle, and from there loads the result stage and the output register, in that order.
// The next command is accepted as soon as the previous word sits in the output
// register, even while rsp_stall holds it there.
// Reset (synchronous, active high) empties the queue; stored keys are not cleared.

module fifo_queue_search_min_max #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_WIDTH   = 32
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_command,
   input  wire  signed [31:0] req_value,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic               rsp_found,
   output logic [3:0]         rsp_match_position,
   output logic [4:0]         rsp_item_count,
   output logic signed [31:0] rsp_minimum,
   output logic signed [31:0] rsp_maximum
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                        accept;
   logic                        queue_full, queue_empty;
   logic signed [KEY_WIDTH-1:0] req_key;
   fqsm_pkg::cell_ctl_type      ctl;

   logic [QUEUE_DEPTH-1:0]      cell_valid;
   logic signed [KEY_WIDTH-1:0] cell_key [QUEUE_DEPTH];
   fqsm_pkg::tok_flags_type     tok_flags [QUEUE_DEPTH];
   logic [IDX_W-1:0]            tok_pos [QUEUE_DEPTH];
   logic signed [KEY_WIDTH-1:0] tok_min [QUEUE_DEPTH];
   logic signed [KEY_WIDTH-1:0] tok_max [QUEUE_DEPTH];

   logic                        busy_ff, busy_in;
   logic                        start_ff;
   logic [1:0]                  cmd_ff;
   logic signed [KEY_WIDTH-1:0] find_key_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [1:0]                  status_ff, status_in;
   logic signed [KEY_WIDTH-1:0] removed_ff, removed_in;

   logic                        res_valid_ff, res_valid_in;
   logic                        res_found_ff;
   logic [IDX_W-1:0]            res_pos_ff;
   logic signed [KEY_WIDTH-1:0] res_min_ff, res_max_ff;
   logic                        res_move;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff;
   logic signed [31:0]          rsp_removed_ff, rsp_min_ff, rsp_max_ff;
   logic                        rsp_found_ff;
   logic [3:0]                  rsp_pos_ff;
   logic [4:0]                  rsp_count_ff;
   logic signed [31:0]          removed_out, min_out, max_out;

   fqsm_pkg::tok_flags_type     tok_start;

   // Narrow keys wrap on entry; wide keys take the sign of the word.
   generate
      if (KEY_WIDTH <= 32) begin : g_key_narrow
         assign req_key     = req_value[KEY_WIDTH-1:0];
         assign removed_out = 32'(removed_ff);
         assign min_out     = 32'(res_min_ff);
         assign max_out     = 32'(res_max_ff);
      end else begin : g_key_wide
         assign req_key     = KEY_WIDTH'(req_value);
         assign removed_out = removed_ff[31:0];
         assign min_out     = res_min_ff[31:0];
         assign max_out     = res_max_ff[31:0];
      end
   endgenerate

   assign req_stall   = busy_ff;
   assign accept      = req_valid & ~busy_ff;
   assign queue_full  = cell_valid[QUEUE_DEPTH-1];
   assign queue_empty = ~cell_valid[0];

   assign ctl.ins    = accept & (req_command == fqsm_pkg::CMD_INSERT);
   assign ctl.shift  = accept & (req_command == fqsm_pkg::CMD_REMOVE) & ~queue_empty;
   assign ctl.search = (cmd_ff == fqsm_pkg::CMD_SEARCH);

   always_comb begin
      status_in  = fqsm_pkg::ST_OK;
      removed_in = '0;
      count_in   = count_ff;
      unique case (req_command)
         fqsm_pkg::CMD_INSERT: begin
            if (queue_full) begin
               status_in = fqsm_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         fqsm_pkg::CMD_REMOVE: begin
            if (queue_empty) begin
               status_in = fqsm_pkg::ST_EMPTY;
            end else begin
               removed_in = cell_key[0];
               count_in   = count_ff - CNT_W'(1);
            end
         end
         fqsm_pkg::CMD_SEARCH, fqsm_pkg::CMD_QUERY: begin
            status_in = fqsm_pkg::ST_OK;
         end
      endcase
   end

   assign tok_start.live  = start_ff;
   assign tok_start.have  = 1'b0;
   assign tok_start.found = 1'b0;

   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         fqsm_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .INDEX_WIDTH(IDX_W),
            .CELL_INDEX (i)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .wr_key       (req_key),
            .find_key     (find_key_ff),
            .prev_valid   ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
            .next_valid   ((i == QUEUE_DEPTH-1) ? 1'b0
                           : cell_valid[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .next_key     ((i == QUEUE_DEPTH-1) ? '0
                           : cell_key[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .valid        (cell_valid[i]),
            .key          (cell_key[i]),
            .tok_in_flags ((i == 0) ? tok_start : tok_flags[(i == 0) ? 0 : i-1]),
            .tok_in_pos   ((i == 0) ? '0 : tok_pos[(i == 0) ? 0 : i-1]),
            .tok_in_min   ((i == 0) ? '0 : tok_min[(i == 0) ? 0 : i-1]),
            .tok_in_max   ((i == 0) ? '0 : tok_max[(i == 0) ? 0 : i-1]),
            .tok_out_flags(tok_flags[i]),
            .tok_out_pos  (tok_pos[i]),
            .tok_out_min  (tok_min[i]),
            .tok_out_max  (tok_max[i])
         );
      end
   endgenerate

   // The result stage frees the chain; it drains into the output register.
   assign res_move = res_valid_ff & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (res_move) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      if (tok_flags[QUEUE_DEPTH-1].live) begin
         res_valid_in = 1'b1;
      end else if (res_move) begin
         res_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= accept;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_command;
         find_key_ff <= req_key;
         status_ff   <= status_in;
         removed_ff  <= removed_in;
      end
      if (tok_flags[QUEUE_DEPTH-1].live) begin
         res_found_ff <= tok_flags[QUEUE_DEPTH-1].found;
         res_pos_ff   <= tok_pos[QUEUE_DEPTH-1];
         res_min_ff   <= tok_flags[QUEUE_DEPTH-1].have ? tok_min[QUEUE_DEPTH-1] : '0;
         res_max_ff   <= tok_flags[QUEUE_DEPTH-1].have ? tok_max[QUEUE_DEPTH-1] : '0;
      end
      if (res_move) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_out;
         rsp_found_ff   <= res_found_ff;
         rsp_pos_ff     <= 4'(res_pos_ff);
         rsp_count_ff   <= 5'(count_ff);
         rsp_min_ff     <= min_out;
         rsp_max_ff     <= max_out;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_item_count     = rsp_count_ff;
   assign rsp_minimum        = rsp_min_ff;
   assign rsp_maximum        = rsp_max_ff;

   // Occupancy count and occupied cells agree.
   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("count does not match occupied cells");

   // Occupied cells form an unbroken run from the head.
   assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + QUEUE_DEPTH'(1))) == '0)
      else $error("gap in occupied cells");

   // A finished scan only exists while a command is in flight.
   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> busy_ff)
      else $error("result stage loaded while idle");

   // No new token enters while one is still walking the chain.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !busy_in || busy_ff && !tok_flags[0].live)
      else $error("scan token overlap");

endmodule

`default_nettype wire
